// File: hw/rtl/html_byte_tokenizer_macros.svh
// Assertion macros used by the tokenizer checker.
`ifndef HTML_BYTE_TOKENIZER_MACROS_SVH
`define HTML_BYTE_TOKENIZER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, idle during reset.
`define HTOK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, idle during reset.
`define HTOK_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/htok_pkg.sv
// Shared types, constants and lookup tables of the HTML byte tokenizer.
package htok_pkg;

  localparam int LEN_W = 6;

  localparam logic [1:0] KIND_SRC  = 2'd0;
  localparam logic [1:0] KIND_LIT  = 2'd1;
  localparam logic [1:0] KIND_STAG = 2'd2;
  localparam logic [1:0] KIND_ETAG = 2'd3;

  localparam logic [20:0] CP_MAX = 21'h10FFFF;
  localparam logic [7:0] UTF_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF_LEAD4 = 8'hF0;
  localparam logic [7:0] UTF_CONT  = 8'h80;
  localparam logic [7:0] UTF_MASK  = 8'h3F;

  localparam int NUM_REFS = 20;

  // Work items passed from the parser to the emitter.
  typedef enum logic [2:0] {
    CMD_BYTE = 3'd0,
    CMD_TAG  = 3'd1,
    CMD_RAW  = 3'd2,
    CMD_LIT  = 3'd3,
    CMD_REF  = 3'd4
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t          op;
    logic             last;
    logic [1:0]       kind;
    logic             sc;
    logic             semi;
    logic [7:0]       data;
    logic [LEN_W-1:0] len;
  } cmd_t;

  // Store write port driven by the parser.
  typedef struct packed {
    logic             tag_we;
    logic             ent_we;
    logic [LEN_W-1:0] addr;
    logic [7:0]       data;
  } wr_t;

  typedef struct packed {
    logic [2:0]  len;
    logic [47:0] name;
    logic [20:0] cp;
  } ref_ent_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= "A" && c <= "Z") r = c + 8'd32;
    return r;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9");
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D || c == 8'h0C;
  endfunction

  // Names of the raw-text elements, first character in the top byte.
  function automatic logic [3:0] raw_len(input logic [1:0] k);
    logic [3:0] r;
    unique case (k)
      2'd1:    r = 4'd5;
      2'd2:    r = 4'd8;
      default: r = 4'd6;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] raw_char(input logic [1:0] k, input logic [2:0] i);
    logic [63:0] nm;
    unique case (k)
      2'd1:    nm = {"style", 24'h0};
      2'd2:    nm = "template";
      default: nm = {"script", 16'h0};
    endcase
    return nm[63 - 8 * i -: 8];
  endfunction

  // Named character references.
  function automatic ref_ent_t ref_entry(input logic [4:0] k);
    ref_ent_t e;
    unique case (k)
      5'd0:    e = '{3'd3, {"amp", 24'h0}, 21'h26};
      5'd1:    e = '{3'd2, {"lt", 32'h0}, 21'h3C};
      5'd2:    e = '{3'd2, {"gt", 32'h0}, 21'h3E};
      5'd3:    e = '{3'd4, {"quot", 16'h0}, 21'h22};
      5'd4:    e = '{3'd4, {"apos", 16'h0}, 21'h27};
      5'd5:    e = '{3'd4, {"nbsp", 16'h0}, 21'h00A0};
      5'd6:    e = '{3'd5, {"mdash", 8'h0}, 21'h2014};
      5'd7:    e = '{3'd5, {"ndash", 8'h0}, 21'h2013};
      5'd8:    e = '{3'd6, "hellip", 21'h2026};
      5'd9:    e = '{3'd5, {"rsquo", 8'h0}, 21'h2019};
      5'd10:   e = '{3'd5, {"lsquo", 8'h0}, 21'h2018};
      5'd11:   e = '{3'd5, {"rdquo", 8'h0}, 21'h201D};
      5'd12:   e = '{3'd5, {"ldquo", 8'h0}, 21'h201C};
      5'd13:   e = '{3'd4, {"copy", 16'h0}, 21'h00A9};
      5'd14:   e = '{3'd3, {"reg", 24'h0}, 21'h00AE};
      5'd15:   e = '{3'd5, {"trade", 8'h0}, 21'h2122};
      5'd16:   e = '{3'd3, {"deg", 24'h0}, 21'h00B0};
      5'd17:   e = '{3'd6, "middot", 21'h00B7};
      5'd18:   e = '{3'd4, {"bull", 16'h0}, 21'h2022};
      5'd19:   e = '{3'd5, {"times", 8'h0}, 21'h00D7};
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

// File: hw/rtl/htok_front.sv
// Parser front end: accepts input words, runs the tokenizer state machine, issues commands.
module htok_front import htok_pkg::*; #(
  parameter int TAG_NAME_DEPTH = 32,
  parameter int ENTITY_DEPTH   = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_op,
  input  logic [7:0] in_byte_in,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd,
  output wr_t        wr,
  input  logic       store_done
);

  localparam int TAW = $clog2(TAG_NAME_DEPTH);
  localparam int EAW = $clog2(ENTITY_DEPTH);

  typedef enum logic [15:0] {
    F_TEXT        = 16'h0001,
    F_TAG_OPEN    = 16'h0002,
    F_TAG_NAME    = 16'h0004,
    F_BEFORE_ATTR = 16'h0008,
    F_ATTR_NAME   = 16'h0010,
    F_AFTER_ATTR  = 16'h0020,
    F_BEFORE_VAL  = 16'h0040,
    F_VAL_QUOTED  = 16'h0080,
    F_VAL_PLAIN   = 16'h0100,
    F_SELF_CLOSE  = 16'h0200,
    F_ENTITY      = 16'h0400,
    F_MARKUP      = 16'h0800,
    F_COMMENT     = 16'h1000,
    F_DECL        = 16'h2000,
    F_RAWTEXT     = 16'h4000,
    F_RAW_MAYBE   = 16'h8000
  } front_state_t;

  front_state_t st_r, st_nxt;
  logic           h_valid_r, h_valid_nxt;
  logic           h_op_r;
  logic [7:0]     h_byte_r;
  logic [TAW-1:0] tlen_r, tlen_nxt;
  logic [EAW-1:0] elen_r, elen_nxt;
  logic           closing_r, closing_nxt;
  logic           quote_r, quote_nxt;
  logic [1:0]     raw_kind_r, raw_kind_nxt;
  logic [3:0]     rpos_r, rpos_nxt;
  logic [1:0]     dash_r, dash_nxt;
  logic [2:0]     rawm_r, rawm_nxt;
  logic [2:0]     busy_r, busy_nxt;

  logic       redo, push, wr_need, fin_req, fin_sc, blk, step, done, accept;
  logic       raw_hit;
  logic [1:0] raw_k, rk;
  logic [3:0] ridx;
  logic [7:0] c, lc;
  cmd_t       cmd;
  wr_t        wr_c;

  assign c  = h_byte_r;
  assign lc = to_lower(h_byte_r);

  // Raw-text element recognized from the running name match.
  always_comb begin
    raw_hit = 1'b0;
    raw_k   = 2'd0;
    if (rawm_r[0] && tlen_r == TAW'(raw_len(2'd0))) begin
      raw_hit = 1'b1;
      raw_k   = 2'd0;
    end else if (rawm_r[1] && tlen_r == TAW'(raw_len(2'd1))) begin
      raw_hit = 1'b1;
      raw_k   = 2'd1;
    end else if (rawm_r[2] && tlen_r == TAW'(raw_len(2'd2))) begin
      raw_hit = 1'b1;
      raw_k   = 2'd2;
    end
  end

  assign rk   = (raw_kind_r == 2'd3) ? 2'd0 : raw_kind_r;
  assign ridx = rpos_r - 4'd1;

  // One step of the tokenizer for the held word.
  always_comb begin
    st_nxt       = st_r;
    tlen_nxt     = tlen_r;
    elen_nxt     = elen_r;
    closing_nxt  = closing_r;
    quote_nxt    = quote_r;
    raw_kind_nxt = raw_kind_r;
    rpos_nxt     = rpos_r;
    dash_nxt     = dash_r;
    rawm_nxt     = rawm_r;
    redo         = 1'b0;
    push         = 1'b0;
    wr_need      = 1'b0;
    fin_req      = 1'b0;
    fin_sc       = 1'b0;
    cmd          = '0;
    cmd.op       = CMD_BYTE;
    cmd.last     = 1'b1;
    wr_c         = '0;
    if (h_op_r) begin
      // End of input flushes a pending reference without its semicolon.
      if (st_r == F_ENTITY) begin
        push     = 1'b1;
        cmd.op   = CMD_LIT;
        cmd.len  = LEN_W'(elen_r);
        st_nxt   = F_TEXT;
        elen_nxt = '0;
      end
    end else begin
      unique case (st_r)
        F_TEXT: begin
          if (c == "<") begin
            st_nxt      = F_TAG_OPEN;
            tlen_nxt    = '0;
            closing_nxt = 1'b0;
            rawm_nxt    = 3'b111;
          end else if (c == "&") begin
            st_nxt   = F_ENTITY;
            elen_nxt = '0;
          end else begin
            push     = 1'b1;
            cmd.kind = KIND_SRC;
            cmd.data = c;
          end
        end
        F_TAG_OPEN: begin
          if (c == "/") closing_nxt = 1'b1;
          else if (c == "!") begin
            st_nxt   = F_MARKUP;
            dash_nxt = 2'd0;
          end else if (c == "?") st_nxt = F_DECL;
          else begin
            st_nxt = F_TAG_NAME;
            redo   = 1'b1;
          end
        end
        F_TAG_NAME: begin
          if (is_alnum(c)) begin
            if (tlen_r < TAW'(TAG_NAME_DEPTH - 1)) begin
              wr_need     = 1'b1;
              wr_c.tag_we = 1'b1;
              wr_c.addr   = LEN_W'(tlen_r);
              wr_c.data   = lc;
              tlen_nxt    = tlen_r + 1'b1;
              for (int k = 0; k < 3; k++) begin
                rawm_nxt[k] = rawm_r[k] && (tlen_r < TAW'(8)) &&
                              (lc == raw_char(2'(k), tlen_r[2:0]));
              end
            end
          end else if (c == ">") fin_req = 1'b1;
          else if (c == "/") st_nxt = F_SELF_CLOSE;
          else st_nxt = F_BEFORE_ATTR;
        end
        F_BEFORE_ATTR: begin
          if (is_space(c)) st_nxt = F_BEFORE_ATTR;
          else if (c == ">") fin_req = 1'b1;
          else if (c == "/") st_nxt = F_SELF_CLOSE;
          else begin
            st_nxt = F_ATTR_NAME;
            redo   = 1'b1;
          end
        end
        F_ATTR_NAME: begin
          if (c == "=") st_nxt = F_BEFORE_VAL;
          else if (c == ">") fin_req = 1'b1;
          else if (c == "/") st_nxt = F_SELF_CLOSE;
          else if (is_space(c)) st_nxt = F_AFTER_ATTR;
        end
        F_AFTER_ATTR: begin
          if (is_space(c)) st_nxt = F_AFTER_ATTR;
          else if (c == "=") st_nxt = F_BEFORE_VAL;
          else begin
            st_nxt = F_BEFORE_ATTR;
            redo   = 1'b1;
          end
        end
        F_BEFORE_VAL: begin
          if (is_space(c)) st_nxt = F_BEFORE_VAL;
          else if (c == 8'h22 || c == 8'h27) begin
            quote_nxt = (c == 8'h27);
            st_nxt    = F_VAL_QUOTED;
          end else if (c == ">") fin_req = 1'b1;
          else st_nxt = F_VAL_PLAIN;
        end
        F_VAL_QUOTED: begin
          if (c == (quote_r ? 8'h27 : 8'h22)) st_nxt = F_BEFORE_ATTR;
        end
        F_VAL_PLAIN: begin
          if (is_space(c)) st_nxt = F_BEFORE_ATTR;
          else if (c == ">") fin_req = 1'b1;
        end
        F_SELF_CLOSE: begin
          if (c == ">") begin
            fin_req = 1'b1;
            fin_sc  = 1'b1;
          end else begin
            st_nxt = F_BEFORE_ATTR;
            redo   = 1'b1;
          end
        end
        F_ENTITY: begin
          if (c == ";") begin
            st_nxt   = F_TEXT;
            push     = 1'b1;
            cmd.op   = CMD_REF;
            cmd.semi = 1'b1;
            cmd.len  = LEN_W'(elen_r);
          end else if (elen_r >= EAW'(ENTITY_DEPTH - 1) || c == "<" || c == "&" ||
                       is_space(c)) begin
            // Broken reference: literal burst, then the byte is seen again as text.
            push     = 1'b1;
            cmd.op   = CMD_LIT;
            cmd.len  = LEN_W'(elen_r);
            cmd.last = (c == "<") || (c == "&");
            st_nxt   = F_TEXT;
            redo     = 1'b1;
          end else begin
            wr_need     = 1'b1;
            wr_c.ent_we = 1'b1;
            wr_c.addr   = LEN_W'(elen_r);
            wr_c.data   = c;
            elen_nxt    = elen_r + 1'b1;
          end
        end
        F_MARKUP: begin
          if (c == "-") begin
            dash_nxt = dash_r + 2'd1;
            if (dash_r + 2'd1 >= 2'd2) begin
              st_nxt   = F_COMMENT;
              dash_nxt = 2'd0;
            end
          end else begin
            st_nxt = F_DECL;
            redo   = 1'b1;
          end
        end
        F_COMMENT: begin
          if (c == "-") begin
            if (dash_r < 2'd2) dash_nxt = dash_r + 2'd1;
          end else if (c == ">" && dash_r >= 2'd2) st_nxt = F_TEXT;
          else dash_nxt = 2'd0;
        end
        F_DECL: begin
          if (c == ">") st_nxt = F_TEXT;
        end
        F_RAWTEXT: begin
          if (c == "<") begin
            st_nxt   = F_RAW_MAYBE;
            rpos_nxt = 4'd0;
          end
        end
        F_RAW_MAYBE: begin
          if (rpos_r == 4'd0) begin
            if (c == "/") rpos_nxt = 4'd1;
            else st_nxt = F_RAWTEXT;
          end else if (ridx < raw_len(rk)) begin
            if (lc == raw_char(rk, ridx[2:0])) rpos_nxt = rpos_r + 4'd1;
            else st_nxt = F_RAWTEXT;
          end else if (c == ">") begin
            st_nxt   = F_TEXT;
            push     = 1'b1;
            cmd.op   = CMD_RAW;
            cmd.data = {6'd0, rk};
            cmd.len  = LEN_W'(raw_len(rk));
          end else if (!is_space(c)) st_nxt = F_RAWTEXT;
        end
        default: st_nxt = F_TEXT;
      endcase
    end
    // Close of a tag: emit its name unless it is empty; a raw-text start tag enters raw text.
    if (fin_req) begin
      st_nxt = F_TEXT;
      if (tlen_r != '0) begin
        push     = 1'b1;
        cmd.op   = CMD_TAG;
        cmd.len  = LEN_W'(tlen_r);
        cmd.kind = closing_r ? KIND_ETAG : KIND_STAG;
        cmd.sc   = !closing_r && fin_sc;
        if (!closing_r && raw_hit) begin
          raw_kind_nxt = raw_k;
          st_nxt       = F_RAWTEXT;
          rpos_nxt     = 4'd0;
        end
      end
    end
  end

  // A store write waits until no command that reads the stores is in flight.
  assign blk      = (push && q_full) || (wr_need && (busy_r != 3'd0));
  assign step     = h_valid_r && !blk;
  assign done     = step && !redo;
  assign in_stall = h_valid_r && !done;
  assign accept   = in_valid && !in_stall;
  assign q_push   = step && push;
  assign q_cmd    = cmd;

  always_comb begin
    wr        = wr_c;
    wr.tag_we = step && wr_c.tag_we;
    wr.ent_we = step && wr_c.ent_we;
  end

  always_comb begin
    h_valid_nxt = h_valid_r;
    if (accept) h_valid_nxt = 1'b1;
    else if (done) h_valid_nxt = 1'b0;
  end

  // Count of store-reading commands not yet finished by the back end.
  always_comb begin
    busy_nxt = busy_r;
    if (q_push && (cmd.op == CMD_TAG || cmd.op == CMD_LIT || cmd.op == CMD_REF))
      busy_nxt = busy_nxt + 3'd1;
    if (store_done) busy_nxt = busy_nxt - 3'd1;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= F_TEXT;
      h_valid_r  <= 1'b0;
      tlen_r     <= '0;
      elen_r     <= '0;
      closing_r  <= 1'b0;
      quote_r    <= 1'b0;
      raw_kind_r <= 2'd0;
      rpos_r     <= 4'd0;
      dash_r     <= 2'd0;
      rawm_r     <= 3'b000;
      busy_r     <= 3'd0;
    end else begin
      h_valid_r <= h_valid_nxt;
      busy_r    <= busy_nxt;
      if (step) begin
        st_r       <= st_nxt;
        tlen_r     <= tlen_nxt;
        elen_r     <= elen_nxt;
        closing_r  <= closing_nxt;
        quote_r    <= quote_nxt;
        raw_kind_r <= raw_kind_nxt;
        rpos_r     <= rpos_nxt;
        dash_r     <= dash_nxt;
        rawm_r     <= rawm_nxt;
      end
    end
  end

  // Held input word.
  always_ff @(posedge clk) begin
    if (accept) begin
      h_op_r   <= in_op;
      h_byte_r <= in_byte_in;
    end
  end

endmodule

// File: hw/rtl/htok_fifo.sv
// Short command queue between the parser and the emitter.
module htok_fifo import htok_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic valid,
  output logic full
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  cmd_t          slot_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign valid   = cnt_r != '0;
  assign full    = cnt_r == (AW + 1)'(DEPTH);
  assign pop_cmd = slot_r[rp_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW + 1)'(push) - (AW + 1)'(pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_cmd;
  end

endmodule

// File: hw/rtl/htok_back.sv
// Emitter back end: name and reference stores, reference resolution, UTF-8 and output word.
module htok_back import htok_pkg::*; #(
  parameter int TAG_NAME_DEPTH = 32,
  parameter int ENTITY_DEPTH   = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  input  wr_t        wr,
  output logic       store_done,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic       out_self_closing,
  output logic       out_token_end,
  output logic       out_last
);

  localparam int TAW = $clog2(TAG_NAME_DEPTH);
  localparam int EAW = $clog2(ENTITY_DEPTH);

  typedef enum logic [7:0] {
    B_IDLE  = 8'h01,
    B_CONST = 8'h02,
    B_RD    = 8'h04,
    B_OUT   = 8'h08,
    B_AMP   = 8'h10,
    B_SEMI  = 8'h20,
    B_SRD   = 8'h40,
    B_SEX   = 8'h80
  } back_state_t;

  back_state_t       bst_r, bst_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [LEN_W-1:0]  pos_r, pos_nxt;
  logic              cp_mode_r, cp_mode_nxt;
  logic [20:0]       cp_r, cp_nxt;
  logic              num_r, hex_r, ok_r;
  logic [20:0]       v_r;
  logic [NUM_REFS-1:0] nm_r;
  logic              out_valid_r;
  logic [1:0]        kind_r;
  logic [7:0]        byte_r;
  logic              sc_r, te_r, last_r;

  logic [7:0] tag_mem [TAG_NAME_DEPTH];
  logic [7:0] ent_mem [ENTITY_DEPTH];
  logic [7:0] tag_q, ent_q;

  logic              slot, emit, e_fin, e_te, e_sc, scan_go, scan_init;
  logic [1:0]        e_kind;
  logic [7:0]        e_byte;
  logic [7:0]        lc;
  logic              d_ok;
  logic [3:0]        d;
  logic [24:0]       prod;
  logic              sc_num, sc_hex, sc_ok;
  logic [20:0]       sc_v, sc_cp, named_cp;
  logic [NUM_REFS-1:0] sc_nm;
  logic [2:0]        cp_n;
  logic [7:0]        cp_byte;
  ref_ent_t          re;

  // Stores, written by the parser and read with a registered port.
  always_ff @(posedge clk) begin
    if (wr.tag_we) tag_mem[wr.addr[TAW-1:0]] <= wr.data;
    tag_q <= tag_mem[pos_r[TAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (wr.ent_we) ent_mem[wr.addr[EAW-1:0]] <= wr.data;
    ent_q <= ent_mem[pos_r[EAW-1:0]];
  end

  // One character of reference resolution, numeric and named in parallel.
  always_comb begin
    lc       = to_lower(ent_q);
    d_ok     = 1'b0;
    d        = 4'd0;
    prod     = '0;
    sc_num   = num_r;
    sc_hex   = hex_r;
    sc_ok    = ok_r;
    sc_v     = v_r;
    named_cp = '0;
    re       = '0;
    if (ent_q >= "0" && ent_q <= "9") begin
      d_ok = 1'b1;
      d    = ent_q[3:0];
    end else if (hex_r && lc >= "a" && lc <= "f") begin
      d_ok = 1'b1;
      d    = lc[3:0] + 4'd9;
    end
    for (int k = 0; k < NUM_REFS; k++) begin
      sc_nm[k] = nm_r[k] && (pos_r < LEN_W'(6)) &&
                 (lc == ref_entry(5'(k)).name[47 - 8 * pos_r[2:0] -: 8]);
    end
    if (pos_r == '0) begin
      sc_num = (ent_q == "#");
      sc_hex = 1'b0;
      sc_ok  = 1'b1;
      sc_v   = '0;
    end else if (num_r) begin
      if (pos_r == LEN_W'(1) && cmd_r.len > LEN_W'(2) && (ent_q == "x" || ent_q == "X")) begin
        sc_hex = 1'b1;
      end else begin
        if (hex_r) prod = {v_r, 4'b0} + 25'(d);
        else prod = ({4'b0, v_r} << 3) + ({4'b0, v_r} << 1) + 25'(d);
        if (!d_ok || prod > 25'(CP_MAX)) sc_ok = 1'b0;
        sc_v = prod[20:0];
      end
    end
    for (int k = 0; k < NUM_REFS; k++) begin
      re = ref_entry(5'(k));
      if (sc_nm[k] && LEN_W'(re.len) == cmd_r.len) named_cp = named_cp | re.cp;
    end
    if (sc_num) sc_cp = (sc_ok && sc_v != '0) ? sc_v : '0;
    else sc_cp = named_cp;
  end

  // UTF-8 byte for the current position of the code point.
  always_comb begin
    if (cp_r < 21'h80) cp_n = 3'd1;
    else if (cp_r < 21'h800) cp_n = 3'd2;
    else if (cp_r < 21'h10000) cp_n = 3'd3;
    else cp_n = 3'd4;
    cp_byte = UTF_CONT | (cp_r[7:0] & UTF_MASK);
    case (cp_n)
      3'd1: cp_byte = cp_r[7:0];
      3'd2: begin
        if (pos_r == '0) cp_byte = UTF_LEAD2 | {3'b0, cp_r[10:6]};
      end
      3'd3: begin
        if (pos_r == '0) cp_byte = UTF_LEAD3 | {4'b0, cp_r[15:12]};
        else if (pos_r == LEN_W'(1)) cp_byte = UTF_CONT | {2'b0, cp_r[11:6]};
      end
      default: begin
        if (pos_r == '0) cp_byte = UTF_LEAD4 | {5'b0, cp_r[20:18]};
        else if (pos_r == LEN_W'(1)) cp_byte = UTF_CONT | {2'b0, cp_r[17:12]};
        else if (pos_r == LEN_W'(2)) cp_byte = UTF_CONT | {2'b0, cp_r[11:6]};
      end
    endcase
  end

  assign slot = !out_valid_r || !out_stall;

  // Emitter sequencer.
  always_comb begin
    bst_nxt     = bst_r;
    cmd_nxt     = cmd_r;
    pos_nxt     = pos_r;
    cp_mode_nxt = cp_mode_r;
    cp_nxt      = cp_r;
    q_pop       = 1'b0;
    store_done  = 1'b0;
    emit        = 1'b0;
    e_kind      = KIND_LIT;
    e_byte      = '0;
    e_sc        = 1'b0;
    e_te        = 1'b0;
    e_fin       = 1'b0;
    scan_go     = 1'b0;
    scan_init   = 1'b0;
    unique case (bst_r)
      B_IDLE: begin
        if (q_valid) begin
          q_pop       = 1'b1;
          cmd_nxt     = q_cmd;
          pos_nxt     = '0;
          cp_mode_nxt = 1'b0;
          case (q_cmd.op)
            CMD_TAG: bst_nxt = B_RD;
            CMD_LIT: bst_nxt = B_AMP;
            CMD_REF: begin
              if (q_cmd.len == '0) begin
                cmd_nxt.op = CMD_LIT;
                bst_nxt    = B_AMP;
              end else begin
                scan_init = 1'b1;
                bst_nxt   = B_SRD;
              end
            end
            default: bst_nxt = B_CONST;
          endcase
        end
      end
      B_CONST: begin
        if (slot) begin
          emit = 1'b1;
          if (cmd_r.op == CMD_RAW) begin
            e_kind = KIND_ETAG;
            e_byte = raw_char(cmd_r.data[1:0], pos_r[2:0]);
            e_fin  = (pos_r == cmd_r.len - 1'b1);
            e_te   = e_fin;
          end else begin
            e_kind = cmd_r.kind;
            e_byte = cmd_r.data;
            e_fin  = 1'b1;
          end
          pos_nxt = pos_r + 1'b1;
          if (e_fin) bst_nxt = B_IDLE;
        end
      end
      B_RD: bst_nxt = B_OUT;
      B_OUT: begin
        if (slot) begin
          emit = 1'b1;
          if (cp_mode_r) begin
            e_byte = cp_byte;
            e_fin  = (pos_r == LEN_W'(cp_n - 3'd1));
            e_te   = e_fin;
          end else if (cmd_r.op == CMD_TAG) begin
            e_kind = cmd_r.kind;
            e_byte = tag_q;
            e_sc   = cmd_r.sc;
            e_fin  = (pos_r == cmd_r.len - 1'b1);
            e_te   = e_fin;
          end else begin
            e_byte = ent_q;
            e_fin  = (pos_r == cmd_r.len - 1'b1) && !cmd_r.semi;
            e_te   = e_fin;
          end
          pos_nxt = pos_r + 1'b1;
          if (e_fin) begin
            bst_nxt    = B_IDLE;
            store_done = 1'b1;
          end else if (!cp_mode_r && cmd_r.op == CMD_LIT && pos_r == cmd_r.len - 1'b1) begin
            bst_nxt = B_SEMI;
          end else if (cp_mode_r) begin
            bst_nxt = B_OUT;
          end else begin
            bst_nxt = B_RD;
          end
        end
      end
      B_AMP: begin
        if (slot) begin
          emit    = 1'b1;
          e_byte  = "&";
          e_fin   = (cmd_r.len == '0) && !cmd_r.semi;
          e_te    = e_fin;
          pos_nxt = '0;
          if (e_fin) begin
            bst_nxt    = B_IDLE;
            store_done = 1'b1;
          end else if (cmd_r.len == '0) bst_nxt = B_SEMI;
          else bst_nxt = B_RD;
        end
      end
      B_SEMI: begin
        if (slot) begin
          emit       = 1'b1;
          e_byte     = ";";
          e_fin      = 1'b1;
          e_te       = 1'b1;
          bst_nxt    = B_IDLE;
          store_done = 1'b1;
        end
      end
      B_SRD: bst_nxt = B_SEX;
      B_SEX: begin
        scan_go = 1'b1;
        if (pos_r == cmd_r.len - 1'b1) begin
          pos_nxt = '0;
          if (sc_cp != '0) begin
            cp_nxt      = sc_cp;
            cp_mode_nxt = 1'b1;
            bst_nxt     = B_OUT;
          end else begin
            cmd_nxt.op = CMD_LIT;
            bst_nxt    = B_AMP;
          end
        end else begin
          pos_nxt = pos_r + 1'b1;
          bst_nxt = B_SRD;
        end
      end
      default: bst_nxt = B_IDLE;
    endcase
  end

  // Sequencer control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bst_r       <= B_IDLE;
      cp_mode_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      bst_r       <= bst_nxt;
      cp_mode_r   <= cp_mode_nxt;
      out_valid_r <= emit || (out_valid_r && out_stall);
    end
  end

  // Command, position and scan accumulators.
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    pos_r <= pos_nxt;
    cp_r  <= cp_nxt;
    if (scan_init) begin
      nm_r  <= '1;
      num_r <= 1'b0;
      hex_r <= 1'b0;
      ok_r  <= 1'b1;
      v_r   <= '0;
    end else if (scan_go) begin
      nm_r  <= sc_nm;
      num_r <= sc_num;
      hex_r <= sc_hex;
      ok_r  <= sc_ok;
      v_r   <= sc_v;
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (emit) begin
      kind_r <= e_kind;
      byte_r <= e_byte;
      sc_r   <= e_sc;
      te_r   <= e_te;
      last_r <= e_fin && cmd_r.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_byte         = byte_r;
  assign out_self_closing = sc_r;
  assign out_token_end    = te_r;
  assign out_last         = last_r;

endmodule

// File: hw/rtl/html_byte_tokenizer.sv
// Top level of the HTML byte tokenizer: parser, command queue and emitter.
//
// Input channel: in_valid/in_stall carry one word per transfer, either a
// stream byte (in_op = 0, in_byte_in) or an end-of-input marker (in_op = 1).
// Result channel: out_valid/out_stall carry one output word per transfer with
// its kind, byte, self-closing flag, token end flag and a last flag that marks
// the final word caused by one input word. Input words that cause no output
// produce nothing on the result channel.
// Plain text bytes leave one word each: the emitter pops each command in its
// idle state and sends the word from its constant state. A tag-name byte or
// reference byte stored while the emitter still reads the stores waits for it.
// The parser does one state step at a time; a byte that re-enters a new state
// takes a further step. Tag names and literal bursts need a registered store
// read before each word; a terminated reference first scans its body with a
// store read and a scan step per byte, then, if it resolves, sends one to four
// UTF-8 words at one per cycle while out_stall is low.
// Reset is synchronous, active low, and returns the parser to text state with
// the command queue and output register empty. When out_stall is high the
// output word holds, the queue fills, and then in_stall rises.
module html_byte_tokenizer import htok_pkg::*; #(
  parameter int TAG_NAME_DEPTH = 32,
  parameter int ENTITY_DEPTH   = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_op,
  input  logic [7:0] in_byte_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic       out_self_closing,
  output logic       out_token_end,
  output logic       out_last
);

  logic q_push, q_pop, q_valid, q_full, store_done;
  cmd_t push_cmd, pop_cmd;
  wr_t  wr;

  htok_front #(
    .TAG_NAME_DEPTH (TAG_NAME_DEPTH),
    .ENTITY_DEPTH   (ENTITY_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_op      (in_op),
    .in_byte_in (in_byte_in),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (push_cmd),
    .wr         (wr),
    .store_done (store_done)
  );

  htok_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .valid    (q_valid),
    .full     (q_full)
  );

  htok_back #(
    .TAG_NAME_DEPTH (TAG_NAME_DEPTH),
    .ENTITY_DEPTH   (ENTITY_DEPTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_cmd            (pop_cmd),
    .q_pop            (q_pop),
    .wr               (wr),
    .store_done       (store_done),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_byte         (out_byte),
    .out_self_closing (out_self_closing),
    .out_token_end    (out_token_end),
    .out_last         (out_last)
  );

endmodule

// File: hw/rtl/htok_checker.sv
// Port-level checker of the HTML byte tokenizer and its bind.
`include "html_byte_tokenizer_macros.svh"

module htok_checker import htok_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_kind,
  input logic [7:0] out_byte,
  input logic       out_self_closing,
  input logic       out_token_end,
  input logic       out_last
);

  // A stalled output word stays and keeps its byte.
  `HTOK_ASSERT_NXT(a_hold, out_valid && out_stall, out_valid && $stable(out_byte), "output word changed while stalled")

  // Only start-tag names carry the self-closing flag.
  `HTOK_ASSERT_NOW(a_sc_kind, out_valid && out_self_closing, out_kind == KIND_STAG, "self-closing flag outside a start tag")

  // A source text byte is a word of its own and ends its input word.
  `HTOK_ASSERT_NOW(a_src, out_valid && out_kind == KIND_SRC, !out_token_end && out_last, "source text word framed wrong")

  // Inside a tag name or literal burst, no word is marked last.
  `HTOK_ASSERT_NOW(a_mid, out_valid && out_kind != KIND_SRC && !out_token_end, !out_last, "last flag inside a token")

endmodule

bind html_byte_tokenizer htok_checker u_htok_checker (.*);
